/* rtl/jsu_pkg.sv */
package jsu_pkg;

	typedef enum logic [3:0] {
		ST_DATA       = 4'd0,
		ST_DONE       = 4'd1,
		ST_NO_QUOTE   = 4'd2,
		ST_CTRL       = 4'd3,
		ST_BAD_ESC    = 4'd4,
		ST_BAD_HEX    = 4'd5,
		ST_SURROGATE  = 4'd6,
		ST_TRUNC_ESC  = 4'd7,
		ST_TRUNC_UNI  = 4'd8,
		ST_UNTERM     = 4'd9
	} status_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_STR  = 3'd1,
		MODE_ESC  = 3'd2,
		MODE_HEX0 = 3'd3,
		MODE_HEX1 = 3'd4,
		MODE_HEX2 = 3'd5,
		MODE_HEX3 = 3'd6
	} mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		status_t    status;
		logic       last;
	} out_t;

	// all results caused by one input byte: data bytes first, then an optional status
	typedef struct packed {
		logic [1:0]      ndata;
		logic [2:0][7:0] data;
		logic            has_st;
		status_t         st;
	} bundle_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] val;
	} esc_t;

	typedef struct packed {
		logic [1:0]      n;
		logic [2:0][7:0] b;
	} utf8_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CTRL_LIM  = 8'h20;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r.val = 4'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66)
			r.val = 4'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46)
			r.val = 4'(c - 8'h37);
		else
			r.ok = 1'b0;
		return r;
	endfunction

	function automatic esc_t simple_escape(input logic [7:0] c);
		esc_t r;
		r.ok = 1'b1;
		case (c)
			CH_QUOTE:  r.val = 8'h22;
			CH_BSLASH: r.val = 8'h5C;
			CH_SLASH:  r.val = 8'h2F;
			8'h62:     r.val = 8'h08; // b
			8'h66:     r.val = 8'h0C; // f
			8'h6E:     r.val = 8'h0A; // n
			8'h72:     r.val = 8'h0D; // r
			8'h74:     r.val = 8'h09; // t
			default: begin
				r.ok  = 1'b0;
				r.val = 8'h00;
			end
		endcase
		return r;
	endfunction

	function automatic utf8_t utf8_encode(input logic [15:0] cp);
		utf8_t r;
		r.b = '0;
		if (cp <= 16'h007F) begin
			r.n    = 2'd1;
			r.b[0] = cp[7:0];
		end else if (cp <= 16'h07FF) begin
			r.n    = 2'd2;
			r.b[0] = 8'hC0 | {3'b000, cp[10:6]};
			r.b[1] = 8'h80 | {2'b00, cp[5:0]};
		end else begin
			r.n    = 2'd3;
			r.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
			r.b[1] = 8'h80 | {2'b00, cp[11:6]};
			r.b[2] = 8'h80 | {2'b00, cp[5:0]};
		end
		return r;
	endfunction

endpackage

/* rtl/jsu_front.sv */
module jsu_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  jsu_pkg::in_t   item,
	output logic           bundle_valid,
	output jsu_pkg::bundle_t bundle
);
	import jsu_pkg::*;

	mode_t       mode_q, mode_n;
	logic [15:0] cp_q, cp_n;
	logic [7:0]  c;
	logic        eot;
	logic [15:0] cp_shift;
	hex_t        hx;
	esc_t        es;
	utf8_t       enc;

	assign c        = item.in_byte;
	assign eot      = item.end_of_text;
	assign hx       = hex_value(c);
	assign es       = simple_escape(c);
	assign cp_shift = {cp_q[11:0], hx.val};
	assign enc      = utf8_encode(cp_shift);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			cp_q   <= '0;
		end else if (accept) begin
			mode_q <= mode_n;
			cp_q   <= cp_n;
		end
	end

	always_comb begin
		mode_n = mode_q;
		cp_n   = cp_q;
		bundle = '0;
		bundle.st = ST_DATA;
		case (mode_q)
			MODE_STR: begin
				if (c == CH_QUOTE) begin
					bundle.has_st = 1'b1;
					bundle.st     = ST_DONE;
					mode_n        = MODE_IDLE;
				end else if (c < CTRL_LIM) begin
					bundle.has_st = 1'b1;
					bundle.st     = ST_CTRL;
					mode_n        = MODE_IDLE;
				end else if (c == CH_BSLASH) begin
					mode_n = MODE_ESC;
					if (eot) begin
						bundle.has_st = 1'b1;
						bundle.st     = ST_TRUNC_ESC;
					end
				end else begin
					bundle.ndata   = 2'd1;
					bundle.data[0] = c;
				end
			end
			MODE_ESC: begin
				if (es.ok) begin
					bundle.ndata   = 2'd1;
					bundle.data[0] = es.val;
					mode_n         = MODE_STR;
				end else if (c == CH_U) begin
					cp_n   = '0;
					mode_n = MODE_HEX0;
					if (eot) begin
						bundle.has_st = 1'b1;
						bundle.st     = ST_TRUNC_UNI;
					end
				end else begin
					bundle.has_st = 1'b1;
					bundle.st     = ST_BAD_ESC;
					mode_n        = MODE_IDLE;
				end
			end
			MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
				if (!hx.ok) begin
					bundle.has_st = 1'b1;
					bundle.st     = ST_BAD_HEX;
					mode_n        = MODE_IDLE;
				end else begin
					cp_n = cp_shift;
					if (mode_q != MODE_HEX3) begin
						case (mode_q)
							MODE_HEX0: mode_n = MODE_HEX1;
							MODE_HEX1: mode_n = MODE_HEX2;
							default:   mode_n = MODE_HEX3;
						endcase
						if (eot) begin
							bundle.has_st = 1'b1;
							bundle.st     = ST_TRUNC_UNI;
						end
					end else if (cp_shift[15:11] == 5'b11011) begin
						// 0xD800..0xDFFF
						bundle.has_st = 1'b1;
						bundle.st     = ST_SURROGATE;
						mode_n        = MODE_IDLE;
					end else begin
						bundle.ndata = enc.n;
						bundle.data  = enc.b;
						mode_n       = MODE_STR;
					end
				end
			end
			default: begin
				if (c == CH_QUOTE) begin
					mode_n = MODE_STR;
				end else begin
					bundle.has_st = 1'b1;
					bundle.st     = ST_NO_QUOTE;
					mode_n        = MODE_IDLE;
				end
			end
		endcase
		if (eot) begin
			if (!bundle.has_st && mode_n != MODE_IDLE) begin
				bundle.has_st = 1'b1;
				bundle.st     = ST_UNTERM;
			end
			mode_n = MODE_IDLE;
		end
	end

	assign bundle_valid = accept && (bundle.has_st || bundle.ndata != 2'd0);

	a_eot_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && eot |=> mode_q == MODE_IDLE)
		else $error("mode not idle after end of text");

	a_push_accept: assert property (@(posedge clk) disable iff (!arst_n)
		bundle_valid |-> accept)
		else $error("bundle pushed without an accepted byte");

	a_hex3_exit: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode_q == MODE_HEX3 |=> mode_q == MODE_STR || mode_q == MODE_IDLE)
		else $error("fourth hex digit left decoder inside escape");

	a_status_ends: assert property (@(posedge clk) disable iff (!arst_n)
		bundle_valid && bundle.has_st |=> mode_q == MODE_IDLE)
		else $error("status result did not return to idle");
endmodule

/* rtl/jsu_queue.sv */
module jsu_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jsu_pkg::bundle_t push_data,
	input  logic             pop,
	output logic             full,
	output logic             valid,
	output jsu_pkg::bundle_t head
);
	import jsu_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t         entries_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign head    = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push)
			entries_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full && !do_pop |=> full)
		else $error("queue left full without a pop");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		!valid |-> wr_ptr_q == rd_ptr_q)
		else $error("pointers differ while queue empty");
endmodule

/* rtl/jsu_back.sv */
module jsu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  jsu_pkg::bundle_t head,
	input  logic             pop,
	output logic             empty,
	output jsu_pkg::out_t    result,
	output logic             deq
);
	import jsu_pkg::*;

	logic [1:0] idx_q;
	logic [2:0] total;
	logic       is_last;
	logic       xfer;

	assign total   = {1'b0, head.ndata} + {2'b00, head.has_st};
	assign is_last = ({1'b0, idx_q} + 3'd1) == total;
	assign empty   = !head_valid;
	assign xfer    = pop && head_valid;
	assign deq     = xfer && is_last;

	always_comb begin
		if (idx_q < head.ndata) begin
			result.out_byte = head.data[idx_q];
			result.status   = ST_DATA;
		end else begin
			result.out_byte = 8'h00;
			result.status   = head.st;
		end
		result.last = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (xfer)
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> {1'b0, idx_q} < total)
		else $error("result index past end of bundle");

	a_idx_reset: assert property (@(posedge clk) disable iff (!arst_n)
		deq |=> idx_q == 2'd0)
		else $error("index not rewound after last transfer");

	a_status_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && result.status != ST_DATA |-> result.last)
		else $error("status result not final");
endmodule

/* rtl/json_string_unescape_utf8.sv */
// A byte's results enter the queue as it transfers in; the queue head drives result.
// Throughput: one input byte per cycle when each byte yields at most one result and pop
// does not stall; a \u escape that encodes to two or three UTF-8 bytes needs one pop per
// byte, and the bundle queue (QUEUE_DEPTH entries) absorbs the burst.
// Reset (arst_n low): decoder idle awaiting an opening quote, queue empty.
module json_string_unescape_utf8 #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  jsu_pkg::in_t  item,
	input  logic          pop,
	output logic          empty,
	output jsu_pkg::out_t result
);
	import jsu_pkg::*;

	logic    accept;
	logic    bundle_valid;
	bundle_t bundle;
	logic    head_valid;
	bundle_t head;
	logic    deq;

	assign accept = push && !full;

	jsu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (item),
		.bundle_valid (bundle_valid),
		.bundle       (bundle)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (bundle_valid),
		.push_data (bundle),
		.pop       (deq),
		.full      (full),
		.valid     (head_valid),
		.head      (head)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.empty      (empty),
		.result     (result),
		.deq        (deq)
	);
endmodule

/* test/tb_json_string_unescape_utf8.sv */
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8;
	import jsu_pkg::*;

	typedef struct {
		logic [7:0] b;
		logic       eot;
		logic       typed;
		status_t    st;
	} dir_row_t;

	localparam int N_DIR  = 33;
	localparam int N_RAND = 325;
	// escape letters that map to a single byte
	localparam logic [63:0] SIMPLE_ESC = "\"\\/bfnrt";

	logic  clk;
	logic  arst_n;
	logic  push;
	logic  full;
	in_t   item;
	logic  pop;
	logic  empty;
	out_t  result;

	out_t  want_q[$];
	out_t  decoded_now[$];
	in_t   text_q[$];
	mode_t dec_mode = MODE_IDLE;
	logic [15:0] dec_cp = '0;
	logic  tx_lazy = 1'b1;
	int    err_count = 0;

	// typed rows carry their status result; the others go through the decoder model
	dir_row_t dir_rows [N_DIR] = '{
		'{"x",       1'b0, 1'b1, ST_NO_QUOTE},
		'{CH_QUOTE,  1'b1, 1'b1, ST_UNTERM},
		'{CH_QUOTE,  1'b0, 1'b0, ST_DATA},
		'{CH_BSLASH, 1'b0, 1'b0, ST_DATA},
		'{CH_U,      1'b0, 1'b0, ST_DATA},
		'{"0",       1'b0, 1'b0, ST_DATA},
		'{"0",       1'b0, 1'b0, ST_DATA},
		'{"0",       1'b0, 1'b0, ST_DATA},
		'{"0",       1'b0, 1'b0, ST_DATA},
		'{CH_BSLASH, 1'b0, 1'b0, ST_DATA},
		'{CH_U,      1'b0, 1'b0, ST_DATA},
		'{"D",       1'b0, 1'b0, ST_DATA},
		'{"8",       1'b0, 1'b0, ST_DATA},
		'{"0",       1'b0, 1'b0, ST_DATA},
		'{"F",       1'b0, 1'b1, ST_SURROGATE},
		'{CH_QUOTE,  1'b0, 1'b0, ST_DATA},
		'{CH_BSLASH, 1'b0, 1'b0, ST_DATA},
		'{CH_U,      1'b1, 1'b1, ST_TRUNC_UNI},
		'{CH_QUOTE,  1'b0, 1'b0, ST_DATA},
		'{CH_BSLASH, 1'b0, 1'b0, ST_DATA},
		'{CH_U,      1'b0, 1'b0, ST_DATA},
		'{"g",       1'b1, 1'b1, ST_BAD_HEX},
		'{CH_QUOTE,  1'b0, 1'b0, ST_DATA},
		'{CH_BSLASH, 1'b1, 1'b1, ST_TRUNC_ESC},
		'{CH_QUOTE,  1'b0, 1'b0, ST_DATA},
		'{CH_BSLASH, 1'b0, 1'b0, ST_DATA},
		'{"q",       1'b0, 1'b1, ST_BAD_ESC},
		'{CH_QUOTE,  1'b0, 1'b0, ST_DATA},
		'{8'h1F,     1'b0, 1'b1, ST_CTRL},
		'{CH_QUOTE,  1'b0, 1'b0, ST_DATA},
		'{8'hFF,     1'b1, 1'b0, ST_DATA},
		'{CH_QUOTE,  1'b0, 1'b0, ST_DATA},
		'{CH_QUOTE,  1'b0, 1'b1, ST_DONE}
	};

	json_string_unescape_utf8 dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_err(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic void want_add(input out_t r);
		want_q.insert(want_q.size(), r);
	endfunction

	function automatic void emit_result(input logic [7:0] b, input status_t s);
		out_t r;
		r.out_byte = b;
		r.status   = s;
		r.last     = 1'b0;
		decoded_now.insert(decoded_now.size(), r);
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return {1'b1, 4'(c - "0")};
		if (c >= "a" && c <= "f")
			return {1'b1, 4'(c - "a" + 8'd10)};
		if (c >= "A" && c <= "F")
			return {1'b1, 4'(c - "A" + 8'd10)};
		return 5'd0;
	endfunction

	// decoder model: fills decoded_now with the results of one text byte
	function automatic void unescape_byte(input logic [7:0] c, input logic eot);
		logic       ended;
		logic       esc_ok;
		logic [7:0] esc_val;
		logic [4:0] hv;
		decoded_now.delete();
		ended = 1'b0;
		case (dec_mode)
			MODE_STR: begin
				if (c == CH_QUOTE) begin
					emit_result(8'h00, ST_DONE);
					ended = 1'b1;
					dec_mode = MODE_IDLE;
				end else if (c < CTRL_LIM) begin
					emit_result(8'h00, ST_CTRL);
					ended = 1'b1;
					dec_mode = MODE_IDLE;
				end else if (c == CH_BSLASH) begin
					dec_mode = MODE_ESC;
					if (eot) begin
						emit_result(8'h00, ST_TRUNC_ESC);
						ended = 1'b1;
					end
				end else begin
					emit_result(c, ST_DATA);
				end
			end
			MODE_ESC: begin
				esc_ok = 1'b1;
				esc_val = 8'h00;
				case (c)
					CH_QUOTE, CH_BSLASH, CH_SLASH: esc_val = c;
					"b": esc_val = 8'h08;
					"f": esc_val = 8'h0C;
					"n": esc_val = 8'h0A;
					"r": esc_val = 8'h0D;
					"t": esc_val = 8'h09;
					default: esc_ok = 1'b0;
				endcase
				if (esc_ok) begin
					emit_result(esc_val, ST_DATA);
					dec_mode = MODE_STR;
				end else if (c == CH_U) begin
					dec_cp = '0;
					dec_mode = MODE_HEX0;
					if (eot) begin
						emit_result(8'h00, ST_TRUNC_UNI);
						ended = 1'b1;
					end
				end else begin
					emit_result(8'h00, ST_BAD_ESC);
					ended = 1'b1;
					dec_mode = MODE_IDLE;
				end
			end
			MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
				hv = hex_nibble(c);
				if (!hv[4]) begin
					emit_result(8'h00, ST_BAD_HEX);
					ended = 1'b1;
					dec_mode = MODE_IDLE;
				end else begin
					dec_cp = {dec_cp[11:0], hv[3:0]};
					if (dec_mode != MODE_HEX3) begin
						dec_mode = mode_t'(dec_mode + 3'd1);
						if (eot) begin
							emit_result(8'h00, ST_TRUNC_UNI);
							ended = 1'b1;
						end
					end else if (dec_cp >= 16'hD800 && dec_cp <= 16'hDFFF) begin
						emit_result(8'h00, ST_SURROGATE);
						ended = 1'b1;
						dec_mode = MODE_IDLE;
					end else begin
						if (dec_cp <= 16'h007F) begin
							emit_result(dec_cp[7:0], ST_DATA);
						end else if (dec_cp <= 16'h07FF) begin
							emit_result({3'b110, dec_cp[10:6]}, ST_DATA);
							emit_result({2'b10, dec_cp[5:0]}, ST_DATA);
						end else begin
							emit_result({4'b1110, dec_cp[15:12]}, ST_DATA);
							emit_result({2'b10, dec_cp[11:6]}, ST_DATA);
							emit_result({2'b10, dec_cp[5:0]}, ST_DATA);
						end
						dec_mode = MODE_STR;
					end
				end
			end
			default: begin
				if (c == CH_QUOTE) begin
					dec_mode = MODE_STR;
				end else begin
					emit_result(8'h00, ST_NO_QUOTE);
					ended = 1'b1;
					dec_mode = MODE_IDLE;
				end
			end
		endcase
		if (eot) begin
			if (!ended && dec_mode != MODE_IDLE)
				emit_result(8'h00, ST_UNTERM);
			dec_mode = MODE_IDLE;
		end
		if (decoded_now.size() > 0)
			decoded_now[decoded_now.size() - 1].last = 1'b1;
	endfunction

	task automatic send_byte(input in_t it, input logic typed, input status_t st);
		int gap;
		gap = tx_lazy ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		unescape_byte(it.in_byte, it.end_of_text);
		if (typed)
			want_add('{out_byte: 8'h00, status: st, last: 1'b1});
		else
			foreach (decoded_now[k]) want_add(decoded_now[k]);
	endtask

	// hold off the sender until every pending result has come out
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (want_q.size() != 0);
	endtask

	function automatic void put_byte(input logic [7:0] c);
		in_t t;
		t.in_byte     = c;
		t.end_of_text = 1'b0;
		text_q.insert(text_q.size(), t);
	endfunction

	// one text: a few strings, mostly well formed, with some noise and truncation
	function automatic void build_text();
		int          n_str;
		int          k;
		int          cut;
		int          s;
		logic [7:0]  b;
		logic [3:0]  nib;
		logic [15:0] cp;
		text_q.delete();
		n_str = $urandom_range(1, 3);
		repeat (n_str) begin
			if ($urandom_range(0, 9) == 0)
				put_byte(8'($urandom_range(0, 255)));
			put_byte(CH_QUOTE);
			repeat ($urandom_range(0, 8)) begin
				k = $urandom_range(0, 99);
				if (k < 45) begin
					b = 8'($urandom_range(8'h20, 8'hFF));
					if (b == CH_QUOTE || b == CH_BSLASH)
						b = 8'h7E;
					put_byte(b);
				end else if (k < 65) begin
					put_byte(CH_BSLASH);
					k = $urandom_range(0, 7);
					put_byte(SIMPLE_ESC[8*k +: 8]);
				end else if (k < 90) begin
					case ($urandom_range(0, 9))
						0, 1, 2: cp = 16'($urandom_range(0, 16'h007F));
						3, 4, 5: cp = 16'($urandom_range(16'h0080, 16'h07FF));
						6, 7:    cp = 16'($urandom_range(16'h0800, 16'hD7FF));
						8:       cp = 16'($urandom_range(16'hE000, 16'hFFFF));
						default: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
					endcase
					put_byte(CH_BSLASH);
					put_byte(CH_U);
					for (s = 3; s >= 0; s--) begin
						nib = cp[4*s +: 4];
						if (nib < 4'd10)
							b = "0" + nib;
						else
							b = ($urandom_range(0, 1) ? "A" : "a") + nib - 8'd10;
						put_byte(b);
					end
				end else begin
					put_byte(8'($urandom_range(0, 255)));
				end
			end
			if ($urandom_range(0, 7) != 0)
				put_byte(CH_QUOTE);
		end
		if ($urandom_range(0, 5) == 0) begin
			cut = $urandom_range(0, text_q.size() - 1);
			while (text_q.size() > cut + 1)
				void'(text_q.pop_back());
		end
		// some texts run on into the next one without an end marker
		if ($urandom_range(0, 3) != 0)
			text_q[text_q.size() - 1].end_of_text = 1'b1;
	endfunction

	task automatic check_result(input out_t got);
		out_t want;
		if (want_q.size() == 0) begin
			report_err($sformatf("unexpected result: byte %02h status %0d last %0b",
				got.out_byte, got.status, got.last));
			return;
		end
		want = want_q.pop_front();
		if (got.out_byte !== want.out_byte)
			report_err($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
		if (got.status !== want.status)
			report_err($sformatf("status %0d, want %0d", got.status, want.status));
		if (got.last !== want.last)
			report_err($sformatf("last %0b, want %0b", got.last, want.last));
	endtask

	// result side: random pop stalls, with stretches of none
	initial begin
		int   gap;
		int   n_pop;
		logic lazy;
		pop <= 1'b0;
		n_pop = 0;
		lazy = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (n_pop % 32 == 0)
				lazy = ($urandom_range(0, 2) != 0);
			gap = lazy ? $urandom_range(0, 16) : 0;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			check_result(result);
			n_pop++;
		end
	end

	initial begin
		int n_sent;
		push   <= 1'b0;
		item   <= '0;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_byte('{in_byte: dir_rows[i].b, end_of_text: dir_rows[i].eot},
				dir_rows[i].typed, dir_rows[i].st);
		drain();

		n_sent = 0;
		while (n_sent < N_RAND) begin
			build_text();
			tx_lazy = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 29) == 0)
				drain();
			foreach (text_q[i])
				send_byte(text_q[i], 1'b0, ST_DATA);
			n_sent += text_q.size();
		end

		drain();
		// longer than the longest pop stall, so a stray result still gets popped
		repeat (20) @(posedge clk);
		if (err_count == 0 && want_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
